>>> rtl/core/acob_pkg.sv
// ----------------------------------------------------------------------------
// acob_pkg: shared types and constants for the alpha compositor
// Configuration register layout, reset values, register indexes and the
// arithmetic helpers for sample reduction and division by 255.
// ----------------------------------------------------------------------------
package acob_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int IMG_WIDTH_W = 15;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND_KIND = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOLID_RED       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOLID_GREEN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOLID_BLUE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECKER_LIGHT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECKER_DARK    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_SAMPLES    = 3'd7;

    // Background kinds.
    localparam logic BG_SOLID   = 1'b0;
    localparam logic BG_CHECKER = 1'b1;

    // Reset values.
    localparam logic                   RST_BACKGROUND_KIND = BG_CHECKER;
    localparam logic [7:0]             RST_CHECKER_LIGHT   = 8'd48;
    localparam logic [7:0]             RST_CHECKER_DARK    = 8'd26;
    localparam logic [IMG_WIDTH_W-1:0] RST_IMAGE_WIDTH     = 15'd1920;

    // Arithmetic constants.
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0]  LEVEL_MAX    = 8'd255;
    localparam logic [16:0] ROUND_257    = 17'd128;
    // floor(2^24 / 257) + 1: exact reciprocal for dividends below 2^24.
    localparam logic [16:0] RECIP_257    = 17'd65281;

    typedef struct packed {
        logic                   background_kind;
        logic [7:0]             solid_red;
        logic [7:0]             solid_green;
        logic [7:0]             solid_blue;
        logic [7:0]             checker_light;
        logic [7:0]             checker_dark;
        logic [IMG_WIDTH_W-1:0] image_width;
        logic                   wide_samples;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bg_t;

    // Reduce a raw sample to 8 bits: rounded v/257 for 16-bit data,
    // saturation for 8-bit data.
    function automatic logic [7:0] reduce_sample(input logic [15:0] v, input logic wide);
        logic [16:0] y;
        logic [33:0] prod;
        logic [7:0]  res;
        y    = {1'b0, v} + ROUND_257;
        prod = 34'(y) * 34'(RECIP_257);
        if (wide)
        begin
            res = prod[31:24];
        end
        else if (v > 16'(LEVEL_MAX))
        begin
            res = LEVEL_MAX;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    // floor(x / 255), exact for every x up to 255 * 255, which covers any
    // weighted sum of two 8-bit levels.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

>>> rtl/core/acob_stream_if.sv
// ----------------------------------------------------------------------------
// acob_stream_if: pixel stream interfaces
// Valid/ready channels for the RGBA input stream and the blended output.
// ----------------------------------------------------------------------------
interface acob_pix_in_if;
    logic        valid;
    logic        ready;
    logic        frame_start;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;

    modport source (output valid, output frame_start, output red_in, output green_in,
                    output blue_in, output alpha_in, input ready);
    modport sink   (input valid, input frame_start, input red_in, input green_in,
                    input blue_in, input alpha_in, output ready);
endinterface

interface acob_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, output ready);
endinterface

>>> rtl/core/acob_bg_gen.sv
// ----------------------------------------------------------------------------
// acob_bg_gen: raster position tracking and background level selection
// Tracks column and row of the next pixel together with the position inside
// the current tile, and gives the background colour for the pixel on offer.
// ----------------------------------------------------------------------------
module acob_bg_gen #(
    parameter int TILE      = 8,
    parameter int MAX_WIDTH = 16384
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          frame_start,
    input  acob_pkg::cfg_t cfg,
    output acob_pkg::bg_t  bg
);
    import acob_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > IMG_WIDTH_W) ? CW + 1 : IMG_WIDTH_W;
    localparam int TW = (TILE > 1) ? $clog2(TILE) : 1;
    localparam logic [TW-1:0] TILE_LAST = TW'(TILE - 1);

    logic [CW-1:0] col_reg, col_next, col_cur;
    logic [15:0]   row_reg, row_next, row_cur;
    logic [TW-1:0] col_tile_reg, col_tile_next, col_tile_cur;
    logic [TW-1:0] row_tile_reg, row_tile_next, row_tile_cur;
    logic          col_par_reg, col_par_next, col_par_cur;
    logic          row_par_reg, row_par_next, row_par_cur;
    logic [EW-1:0] width_raw, width_eff, col_plus;
    logic          row_end, tile_dark;
    logic [7:0]    grey;

    // Position of the pixel on offer: a frame start places it at the origin.
    always_comb
    begin
        col_cur      = frame_start ? '0 : col_reg;
        row_cur      = frame_start ? '0 : row_reg;
        col_tile_cur = frame_start ? '0 : col_tile_reg;
        row_tile_cur = frame_start ? '0 : row_tile_reg;
        col_par_cur  = frame_start ? 1'b0 : col_par_reg;
        row_par_cur  = frame_start ? 1'b0 : row_par_reg;
    end

    // Effective width: zero acts as one, and it is capped at the maximum.
    always_comb
    begin
        width_raw = EW'(cfg.image_width);
        if (width_raw == '0)
        begin
            width_eff = EW'(1);
        end
        else if (width_raw > EW'(MAX_WIDTH))
        begin
            width_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_raw;
        end
        col_plus = EW'(col_cur) + EW'(1);
        row_end  = (col_plus >= width_eff);
    end

    // Advance column, row and tile phases after the current pixel.
    always_comb
    begin
        col_next      = CW'(col_plus);
        col_tile_next = (col_tile_cur == TILE_LAST) ? '0 : col_tile_cur + TW'(1);
        col_par_next  = col_par_cur ^ (col_tile_cur == TILE_LAST);
        row_next      = row_cur;
        row_tile_next = row_tile_cur;
        row_par_next  = row_par_cur;
        if (row_end)
        begin
            col_next      = '0;
            col_tile_next = '0;
            col_par_next  = 1'b0;
            if (row_cur == 16'hFFFF)
            begin
                // The row count wraps to zero, which restarts the tile phase.
                row_next      = '0;
                row_tile_next = '0;
                row_par_next  = 1'b0;
            end
            else
            begin
                row_next      = row_cur + 16'd1;
                row_tile_next = (row_tile_cur == TILE_LAST) ? '0 : row_tile_cur + TW'(1);
                row_par_next  = row_par_cur ^ (row_tile_cur == TILE_LAST);
            end
        end
    end

    // Position registers move on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            col_tile_reg <= '0;
            row_tile_reg <= '0;
            col_par_reg  <= 1'b0;
            row_par_reg  <= 1'b0;
        end
        else if (advance)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            col_tile_reg <= col_tile_next;
            row_tile_reg <= row_tile_next;
            col_par_reg  <= col_par_next;
            row_par_reg  <= row_par_next;
        end
    end

    // Background colour: solid, or the grey of the current checker square.
    always_comb
    begin
        tile_dark = col_par_cur ^ row_par_cur;
        grey      = tile_dark ? cfg.checker_dark : cfg.checker_light;
        if (cfg.background_kind == BG_CHECKER)
        begin
            bg.red   = grey;
            bg.green = grey;
            bg.blue  = grey;
        end
        else
        begin
            bg.red   = cfg.solid_red;
            bg.green = cfg.solid_green;
            bg.blue  = cfg.solid_blue;
        end
    end

endmodule

>>> rtl/core/acob_blend_pipe.sv
// ----------------------------------------------------------------------------
// acob_blend_pipe: three-stage blend datapath
// Stage A holds reduced samples and background, stage B the weighted sums,
// stage C the divided result that drives the output channel.
// ----------------------------------------------------------------------------
module acob_blend_pipe (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wide,
    input  acob_pkg::bg_t   bg,
    acob_pix_in_if.sink     pix_in,
    acob_pix_out_if.source  pix_out
);
    import acob_pkg::*;

    logic       a_valid_reg, b_valid_reg, c_valid_reg;
    logic       a_load, b_load, c_load;
    logic [7:0] a_red_reg, a_green_reg, a_blue_reg, a_alpha_reg;
    logic [7:0] a_red_next, a_green_next, a_blue_next, a_alpha_next;
    bg_t        a_bg_reg;
    logic [7:0] inv_alpha;
    logic [15:0] b_red_reg, b_green_reg, b_blue_reg;
    logic [15:0] b_red_next, b_green_next, b_blue_next;
    logic [7:0] c_red_reg, c_green_reg, c_blue_reg;

    // A stage loads when it is empty or its contents move on.
    assign c_load       = !c_valid_reg || pix_out.ready;
    assign b_load       = !b_valid_reg || c_load;
    assign a_load       = !a_valid_reg || b_load;
    assign pix_in.ready = a_load;

    // Stage A: reduce the samples to 8 bits.
    always_comb
    begin
        a_red_next   = reduce_sample(pix_in.red_in, wide);
        a_green_next = reduce_sample(pix_in.green_in, wide);
        a_blue_next  = reduce_sample(pix_in.blue_in, wide);
        a_alpha_next = reduce_sample(pix_in.alpha_in, wide);
    end

    // Stage B: c*a + bg*(255-a) for each colour channel.
    always_comb
    begin
        inv_alpha    = LEVEL_MAX - a_alpha_reg;
        b_red_next   = 16'(a_red_reg) * 16'(a_alpha_reg)
                     + 16'(a_bg_reg.red) * 16'(inv_alpha);
        b_green_next = 16'(a_green_reg) * 16'(a_alpha_reg)
                     + 16'(a_bg_reg.green) * 16'(inv_alpha);
        b_blue_next  = 16'(a_blue_reg) * 16'(a_alpha_reg)
                     + 16'(a_bg_reg.blue) * 16'(inv_alpha);
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= pix_in.valid;
            end
            if (b_load)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_load)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_red_reg   <= a_red_next;
            a_green_reg <= a_green_next;
            a_blue_reg  <= a_blue_next;
            a_alpha_reg <= a_alpha_next;
            a_bg_reg    <= bg;
        end
        if (b_load)
        begin
            b_red_reg   <= b_red_next;
            b_green_reg <= b_green_next;
            b_blue_reg  <= b_blue_next;
        end
        if (c_load)
        begin
            c_red_reg   <= div255(b_red_reg);
            c_green_reg <= div255(b_green_reg);
            c_blue_reg  <= div255(b_blue_reg);
        end
    end

    assign pix_out.valid     = c_valid_reg;
    assign pix_out.red_out   = c_red_reg;
    assign pix_out.green_out = c_green_reg;
    assign pix_out.blue_out  = c_blue_reg;
    assign pix_out.alpha_out = ALPHA_OPAQUE;

endmodule

>>> rtl/core/alpha_composite_over_background.sv
// ----------------------------------------------------------------------------
// alpha_composite_over_background: RGBA stream blended over a background
// Configuration registers, raster position tracking and the blend pipeline.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and gives one blended pixel per clock
// while the output is not stalled. Each pixel passes three register stages
// (sample reduction, weighted sum, division by 255). Input ready drops only
// when all three stages hold pixels and the output is stalled; empty stages
// absorb pixels while a result waits. The background colour for a pixel is
// fixed when it is transferred. Configuration is written through cfg_wr_en,
// cfg_index and cfg_data and should change only while the pipeline is empty.
module alpha_composite_over_background #(
    parameter int TILE      = 8,
    parameter int MAX_WIDTH = 16384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [acob_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [acob_pkg::CFG_DATA_W-1:0]  cfg_data,
    acob_pix_in_if.sink                      pix_in,
    acob_pix_out_if.source                   pix_out
);
    import acob_pkg::*;

    cfg_t cfg_reg;
    bg_t  bg;
    logic in_transfer;

    assign in_transfer = pix_in.valid && pix_in.ready;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.background_kind <= RST_BACKGROUND_KIND;
            cfg_reg.solid_red       <= '0;
            cfg_reg.solid_green     <= '0;
            cfg_reg.solid_blue      <= '0;
            cfg_reg.checker_light   <= RST_CHECKER_LIGHT;
            cfg_reg.checker_dark    <= RST_CHECKER_DARK;
            cfg_reg.image_width     <= RST_IMAGE_WIDTH;
            cfg_reg.wide_samples    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BACKGROUND_KIND: cfg_reg.background_kind <= cfg_data[0];
                REG_SOLID_RED:       cfg_reg.solid_red       <= cfg_data[7:0];
                REG_SOLID_GREEN:     cfg_reg.solid_green     <= cfg_data[7:0];
                REG_SOLID_BLUE:      cfg_reg.solid_blue      <= cfg_data[7:0];
                REG_CHECKER_LIGHT:   cfg_reg.checker_light   <= cfg_data[7:0];
                REG_CHECKER_DARK:    cfg_reg.checker_dark    <= cfg_data[7:0];
                REG_IMAGE_WIDTH:     cfg_reg.image_width     <= cfg_data[IMG_WIDTH_W-1:0];
                REG_WIDE_SAMPLES:    cfg_reg.wide_samples    <= cfg_data[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Position tracking and background selection.
    acob_bg_gen #(
        .TILE      (TILE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_bg_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (in_transfer),
        .frame_start (pix_in.frame_start),
        .cfg         (cfg_reg),
        .bg          (bg)
    );

    // Blend datapath.
    acob_blend_pipe u_blend_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .wide    (cfg_reg.wide_samples),
        .bg      (bg),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

endmodule

>>> rtl/core/acob_checker.sv
// ----------------------------------------------------------------------------
// acob_checker: port-level checks for the alpha compositor
// Watches the stream ports and reports handshake or flow control slips.
// ----------------------------------------------------------------------------
module acob_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_out,
    input logic [7:0] alpha_out
);
    import acob_pkg::*;

    // Nothing is offered while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // Every result is fully opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alpha_out == ALPHA_OPAQUE))
        else $error("output alpha is not opaque");

    // An empty output stage means the pipeline can take a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A draining output never holds back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out))
        else $error("stalled result changed");

endmodule

bind alpha_composite_over_background acob_checker u_acob_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .red_out   (pix_out.red_out),
    .alpha_out (pix_out.alpha_out)
);

>>> tb/alpha_composite_over_background_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_composite_over_background_test: self-checking bench for the compositor
// A short table of directed pixels runs first, then random pixels under a
// series of register settings. Each transferred pixel is blended by a
// behavioural model here, and every output transfer is compared channel by
// channel with the oldest outstanding result, typed in or predicted.
// ----------------------------------------------------------------------------
module alpha_composite_over_background_test;

    import acob_pkg::*;

    localparam int TILE_SIZE      = 8;
    localparam int WIDTH_LIMIT    = 16384;
    localparam int PIPE_DEPTH     = 3;
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_PIXELS   = 115;
    localparam int NUM_DIRECTED   = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        frame_start;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } blended_t;

    typedef struct packed {
        pixel_in_t pix;
        logic      typed_in;
        blended_t  want;
    } directed_row_t;

    // Directed pixels under the reset settings: checkerboard of 48 and 26,
    // width 1920, 8-bit samples. Columns follow the row order from the
    // opening frame start; column 8 is the first dark square.
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{1'b1, 16'h00FF, 16'h0000, 16'h0080, 16'h00FF}, 1'b1, '{8'd255, 8'd0, 8'd128, 8'd255}},
        '{'{1'b0, 16'h0000, 16'h00FF, 16'h00FF, 16'h0000}, 1'b1, '{8'd48, 8'd48, 8'd48, 8'd255}},
        '{'{1'b0, 16'hFFFF, 16'h0100, 16'h012C, 16'hFFFF}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1, '{8'd48, 8'd48, 8'd48, 8'd255}},
        '{'{1'b0, 16'h00C8, 16'h000A, 16'h004D, 16'h0080}, 1'b0, '0},
        '{'{1'b0, 16'hAAAA, 16'h5555, 16'h00FF, 16'h0040}, 1'b0, '0},
        '{'{1'b0, 16'h0001, 16'h0002, 16'h0003, 16'h0001}, 1'b0, '0},
        '{'{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h00FF}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}},
        '{'{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'd26, 8'd26, 8'd26, 8'd255}},
        '{'{1'b0, 16'h0080, 16'h0080, 16'h0080, 16'hFFFF}, 1'b1, '{8'd128, 8'd128, 8'd128, 8'd255}},
        '{'{1'b0, 16'h00FF, 16'h00FF, 16'h00FF, 16'h0000}, 1'b1, '{8'd26, 8'd26, 8'd26, 8'd255}},
        '{'{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'd48, 8'd48, 8'd48, 8'd255}},
        '{'{1'b0, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{'{1'b0, 16'h0064, 16'h0096, 16'h00FA, 16'h00C8}, 1'b0, '0},
        '{'{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'd48, 8'd48, 8'd48, 8'd255}},
        '{'{1'b0, 16'h00FF, 16'h00FF, 16'h00FF, 16'h0001}, 1'b0, '0}
    };

    // Register settings, one per random phase. Phase six narrows the width
    // while the column lies far beyond it.
    localparam cfg_t PHASE_CFG [NUM_PHASES] = '{
        '{BG_CHECKER, 8'd0,   8'd0,   8'd0,   8'd48,  8'd26,  15'd1920,  1'b0},
        '{BG_SOLID,   8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   15'd5,     1'b0},
        '{BG_CHECKER, 8'd17,  8'd34,  8'd51,  8'd255, 8'd0,   15'd0,     1'b1},
        '{BG_CHECKER, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 15'd17,    1'b0},
        '{BG_SOLID,   8'd90,  8'd200, 8'd30,  8'd1,   8'd254, 15'd16384, 1'b1},
        '{BG_CHECKER, 8'd255, 8'd255, 8'd255, 8'd200, 8'd100, 15'd32767, 1'b0},
        '{BG_CHECKER, 8'd255, 8'd255, 8'd255, 8'd200, 8'd100, 15'd3,     1'b1},
        '{BG_SOLID,   8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   15'd1,     1'b1},
        '{BG_CHECKER, 8'd12,  8'd13,  8'd14,  8'd33,  8'd222, 15'd24,    1'b0}
    };

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    acob_pix_in_if  pix_in_ch();
    acob_pix_out_if pix_out_ch();

    alpha_composite_over_background #(
        .TILE      (TILE_SIZE),
        .MAX_WIDTH (WIDTH_LIMIT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in_ch),
        .pix_out   (pix_out_ch)
    );

    // Model state: register copy and raster position.
    cfg_t         active_cfg;
    int unsigned  column_pos;
    logic [15:0]  row_pos;

    blended_t     blended_due [$];
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    int unsigned  pixels_sent;
    int unsigned  pixels_checked;
    int unsigned  error_count;
    int unsigned  quiet_cycles;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Reduce one sample to 8 bits: rounded division by 257 for wide samples,
    // saturation otherwise.
    function automatic logic [7:0] reduced_level(input logic [15:0] v, input logic wide);
        int unsigned s;
        s = v;
        if (wide)
            return 8'((s + 128) / 257);
        return (s > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] weighted_blend(input logic [7:0] c, input logic [7:0] a,
                                                  input logic [7:0] bg);
        int unsigned sum;
        sum = int'(c) * int'(a) + int'(bg) * (255 - int'(a));
        return 8'(sum / 255);
    endfunction

    // Blend one pixel over the current background and advance the position.
    function automatic blended_t composite_pixel(input pixel_in_t p);
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  level;
        int unsigned eff_width;
        int unsigned parity;
        blended_t    res;
        if (p.frame_start)
        begin
            column_pos = 0;
            row_pos    = '0;
        end
        red   = reduced_level(p.red, active_cfg.wide_samples);
        green = reduced_level(p.green, active_cfg.wide_samples);
        blue  = reduced_level(p.blue, active_cfg.wide_samples);
        alpha = reduced_level(p.alpha, active_cfg.wide_samples);
        if (active_cfg.background_kind == BG_CHECKER)
        begin
            parity    = ((column_pos / TILE_SIZE) ^ (int'(row_pos) / TILE_SIZE)) & 1;
            level     = parity ? active_cfg.checker_dark : active_cfg.checker_light;
            res.red   = weighted_blend(red, alpha, level);
            res.green = weighted_blend(green, alpha, level);
            res.blue  = weighted_blend(blue, alpha, level);
        end
        else
        begin
            res.red   = weighted_blend(red, alpha, active_cfg.solid_red);
            res.green = weighted_blend(green, alpha, active_cfg.solid_green);
            res.blue  = weighted_blend(blue, alpha, active_cfg.solid_blue);
        end
        res.alpha = ALPHA_OPAQUE;
        // Position advance with the width clamped to its legal range.
        eff_width = active_cfg.image_width;
        if (eff_width == 0)
            eff_width = 1;
        if (eff_width > WIDTH_LIMIT)
            eff_width = WIDTH_LIMIT;
        if (column_pos + 1 >= eff_width)
        begin
            column_pos = 0;
            row_pos    = row_pos + 16'd1;
        end
        else
        begin
            column_pos = column_pos + 1;
        end
        return res;
    endfunction

    // Random sample biased towards extremes, the 8-bit saturation edge and the rounding edges of /257.
    function automatic logic [15:0] random_sample();
        logic [15:0] v;
        case ($urandom_range(9))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'(257 * $urandom_range(254) + 127 + $urandom_range(1));
            3, 4, 5: v = 16'($urandom_range(255));
            6: v = 16'(255 + $urandom_range(1));
            default: v = 16'($urandom_range(65535));
        endcase
        return v;
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_registers(input cfg_t c);
        write_register(REG_BACKGROUND_KIND, CFG_DATA_W'(c.background_kind));
        write_register(REG_SOLID_RED, CFG_DATA_W'(c.solid_red));
        write_register(REG_SOLID_GREEN, CFG_DATA_W'(c.solid_green));
        write_register(REG_SOLID_BLUE, CFG_DATA_W'(c.solid_blue));
        write_register(REG_CHECKER_LIGHT, CFG_DATA_W'(c.checker_light));
        write_register(REG_CHECKER_DARK, CFG_DATA_W'(c.checker_dark));
        write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width));
        write_register(REG_WIDE_SAMPLES, CFG_DATA_W'(c.wide_samples));
        cfg_wr_en  <= 1'b0;
        active_cfg = c;
    endtask

    // Offer one pixel after a random gap and record its prediction once the
    // transfer has happened.
    task automatic send_pixel(input pixel_in_t p, input logic typed_in, input blended_t want);
        blended_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in_ch.valid       <= 1'b1;
        pix_in_ch.frame_start <= p.frame_start;
        pix_in_ch.red_in      <= p.red;
        pix_in_ch.green_in    <= p.green;
        pix_in_ch.blue_in     <= p.blue;
        pix_in_ch.alpha_in    <= p.alpha;
        @(posedge clk);
        while (!pix_in_ch.ready)
            @(posedge clk);
        predicted = composite_pixel(p);
        blended_due.push_back(typed_in ? want : predicted);
        pixels_sent++;
    endtask

    // Stop offering pixels until every predicted result has come out.
    task automatic hold_until_drained();
        pix_in_ch.valid <= 1'b0;
        @(posedge clk);
        while (blended_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_channel(input string name, input logic [7:0] want,
                                   input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Output side: random back-pressure.
    initial
    begin
        pix_out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            pix_out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checking and the watchdog on stalled traffic.
    always @(posedge clk)
    begin
        blended_t due;
        if (rst_n)
        begin
            if (pix_out_ch.valid && pix_out_ch.ready)
            begin
                if (blended_due.size() == 0)
                begin
                    $display("%0t ns: output transfer with no result outstanding, actual %h",
                             $time, {pix_out_ch.red_out, pix_out_ch.green_out,
                                     pix_out_ch.blue_out, pix_out_ch.alpha_out});
                    error_count++;
                end
                else
                begin
                    due = blended_due.pop_front();
                    compare_channel("red_out", due.red, pix_out_ch.red_out);
                    compare_channel("green_out", due.green, pix_out_ch.green_out);
                    compare_channel("blue_out", due.blue, pix_out_ch.blue_out);
                    compare_channel("alpha_out", due.alpha, pix_out_ch.alpha_out);
                    pixels_checked++;
                end
            end
            if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                             $time, quiet_cycles, blended_due.size());
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        pixel_in_t p;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = REG_BACKGROUND_KIND;
        cfg_data              = '0;
        pix_in_ch.valid       = 1'b0;
        pix_in_ch.frame_start = 1'b0;
        pix_in_ch.red_in      = '0;
        pix_in_ch.green_in    = '0;
        pix_in_ch.blue_in     = '0;
        pix_in_ch.alpha_in    = '0;
        active_cfg            = '{RST_BACKGROUND_KIND, 8'd0, 8'd0, 8'd0, RST_CHECKER_LIGHT,
                                  RST_CHECKER_DARK, RST_IMAGE_WIDTH, 1'b0};
        column_pos            = 0;
        row_pos               = '0;
        send_idle_pct         = 33;
        recv_idle_pct         = 56;
        pixels_sent           = 0;
        pixels_checked        = 0;
        error_count           = 0;
        quiet_cycles          = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_pixel(DIRECTED_ROWS[i].pix, DIRECTED_ROWS[i].typed_in, DIRECTED_ROWS[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Idling: receiver-heavy, then sender-heavy, then none.
            if (ph < 3)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 56;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            hold_until_drained();
            repeat (PIPE_DEPTH + 2) @(posedge clk);
            load_registers(PHASE_CFG[ph]);
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                if (n == PHASE_PIXELS / 2)
                    hold_until_drained();
                p.frame_start = ($urandom_range(63) == 0);
                p.red         = random_sample();
                p.green       = random_sample();
                p.blue        = random_sample();
                p.alpha       = random_sample();
                send_pixel(p, 1'b0, '0);
            end
        end

        hold_until_drained();
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        $display("Composited %0d pixels under %0d register settings: solid and checkerboard",
                 pixels_sent, NUM_PHASES + 1);
        $display("backgrounds, 8- and 16-bit samples, widths 0 to 32767; %0d checked, %0d errors",
                 pixels_checked, error_count);
        if (error_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
